/* rtl/ehps_pkg.sv */
// Package for the ECMP hash path select block: item types, register indexes,
// MurmurHash3 constants and the small per-step hash and modulo functions.
// No dependencies.
package ehps_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPRAY_ENABLE = 1'd1;

  localparam logic [7:0] PROTO_TCP  = 8'h06;
  localparam logic [7:0] PROTO_UDP  = 8'h11;
  localparam logic [7:0] PROTO_ACK  = 8'hFC;
  localparam logic [7:0] PROTO_NACK = 8'hFD;
  localparam logic [7:0] PROTO_CTRL_MIN = 8'hFC;

  localparam logic [1:0] TAG_SPRAY = 2'd2;

  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_N  = 32'he6546b64;
  localparam logic [31:0] MM_F1 = 32'h85ebca6b;
  localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

  localparam logic [31:0] FLOW_KEY_LEN  = 32'd12;
  localparam logic [31:0] SPRAY_KEY_LEN = 32'd16;

  localparam int unsigned KEY_WORDS  = 4;
  localparam int unsigned MOD_STAGES = 4;
  localparam int unsigned MOD_BITS   = 8;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [1:0]  workload_tag;
    logic [4:0]  path_count;
  } ehps_in_t;

  typedef struct packed {
    logic [3:0]  path_index;
    logic [31:0] hash_value;
    logic        unsupported;
  } ehps_out_t;

  typedef struct packed {
    logic       spray;
    logic       unsup;
    logic [4:0] cnt;
  } ehps_meta_t;

  typedef struct packed {
    logic        unsup;
    logic [4:0]  cnt;
    logic [4:0]  rem;
    logic [31:0] hash;
  } ehps_mod_t;

  function automatic logic [31:0] mm_step(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] t;
    t = h ^ k;
    t = {t[18:0], t[31:19]};
    return t + {t[29:0], 2'b00} + MM_N;
  endfunction

  function automatic logic [4:0] mod_step(input logic [4:0] r, input logic b,
                                          input logic [4:0] cnt);
    logic [5:0] t;
    t = {r, b};
    if (t >= {1'b0, cnt}) begin
      t = t - {1'b0, cnt};
    end
    return t[4:0];
  endfunction

endpackage

/* rtl/ehps_mod_stage.sv */
// One registered stage of the hash-modulo-path-count reduction.
// Folds eight hash bits into the remainder per stage; depends on ehps_pkg.
module ehps_mod_stage #(
  parameter int unsigned STG = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  ehps_pkg::ehps_mod_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output ehps_pkg::ehps_mod_t dn_data
);
  import ehps_pkg::*;

  localparam int unsigned TOP = 31 - STG * MOD_BITS;

  logic      vld_r;
  ehps_mod_t data_r;
  ehps_mod_t data_nxt;

  always_comb begin
    data_nxt = up_data;
    for (int i = 0; i < MOD_BITS; i++) begin
      data_nxt.rem = mod_step(data_nxt.rem, up_data.hash[TOP-i], up_data.cnt);
    end
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

  a_rem_below_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (data_r.rem < data_r.cnt))
    else $error("remainder not below path count");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !dn_ready |=> vld_r && $stable(data_r))
    else $error("stalled stage changed");

  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (data_r.cnt != 5'd0))
    else $error("path count zero inside reduction");

endmodule

/* rtl/ecmp_hash_path_select.sv */
// Top level of the ECMP path selector: MurmurHash3 x86_32 over the flow or
// spray key and a pipelined modulo; depends on ehps_pkg and ehps_mod_stage.
//
// Usage:
//   The in_ channel takes one packet header per item (valid/ready), the out_
//   channel returns one result item per header in the same order: the chosen
//   path index, the hash value and the unsupported-protocol flag.
//   The cfg_ port writes hash_seed (index 0) and spray_enable (index 1);
//   write it only while no item is in flight.
//   From acceptance to out_valid an item passes six stages for the key
//   multiplies, the block mixing and the two finalization multiplies, then
//   four stages that reduce the hash modulo the path count, eight bits each.
//   Throughput is one item per cycle while out_ready is high; one 32x32
//   multiply or two block mixing steps per stage set the stage depth.
//   Synchronous active-low reset clears all valid bits and both registers.
//   When the receiver holds out_ready low, items pile up in empty stages;
//   in_ready drops only once every stage holds an item, and nothing is lost
//   or repeated.
module ecmp_hash_path_select #(
  parameter int unsigned MAX_PATHS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ehps_pkg::ehps_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ehps_pkg::ehps_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [ehps_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [ehps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ehps_pkg::*;

  localparam int unsigned CNT_CAP = (MAX_PATHS > 31) ? 31 : MAX_PATHS;
  localparam logic [4:0]  CNT_MAX = CNT_CAP[4:0];

  logic [31:0] hash_seed_r;
  logic        spray_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_seed_r <= '0;
      spray_en_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_HASH_SEED:    hash_seed_r <= cfg_wdata;
        REG_SPRAY_ENABLE: spray_en_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  ehps_meta_t  meta0;
  logic [31:0] word0 [KEY_WORDS];
  logic        control0;
  logic        supported0;

  always_comb begin
    control0   = in_data.protocol >= PROTO_CTRL_MIN;
    supported0 = (in_data.protocol == PROTO_TCP) || (in_data.protocol == PROTO_UDP) ||
                 (in_data.protocol == PROTO_ACK) || (in_data.protocol == PROTO_NACK);
    meta0.spray = spray_en_r && (in_data.workload_tag == TAG_SPRAY) && !control0;
    meta0.unsup = !meta0.spray && !supported0;
    meta0.cnt   = in_data.path_count;
    if (meta0.cnt == 5'd0) begin
      meta0.cnt = 5'd1;
    end
    if (meta0.cnt > CNT_MAX) begin
      meta0.cnt = CNT_MAX;
    end
    word0[0] = in_data.src_ip;
    word0[1] = in_data.dst_ip;
    word0[2] = {in_data.dst_port, in_data.src_port};
    word0[3] = in_data.seq_num;
  end

  logic        v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic        en1, en2, en3, en4, en5, en6, mod_ready;
  ehps_meta_t  meta1_r, meta2_r, meta3_r, meta4_r, meta5_r, meta6_r;
  logic [31:0] p1_r [KEY_WORDS];
  logic [31:0] k2_r [KEY_WORDS];
  logic [31:0] h2_r, k3_r, k4_r;
  logic [31:0] hp_r, m1_r, m2_r;
  logic [31:0] h2_nxt, h3, h4, hx, hp_nxt, m1x, hash6;
  logic [31:0] k2_nxt [KEY_WORDS];

  assign en6 = !v6_r || mod_ready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  always_comb begin
    for (int i = 0; i < KEY_WORDS; i++) begin
      k2_nxt[i] = {p1_r[i][16:0], p1_r[i][31:17]} * MM_C2;
    end
    h2_nxt = mm_step(mm_step(hash_seed_r, k2_r[0]), k2_r[1]);
    h3     = mm_step(h2_r, k3_r);
    h4     = mm_step(h3, k4_r);
    hx     = meta3_r.spray ? (h4 ^ SPRAY_KEY_LEN) : (h3 ^ FLOW_KEY_LEN);
    hp_nxt = hx ^ (hx >> 16);
    m1x    = m1_r ^ (m1_r >> 13);
    hash6  = meta6_r.unsup ? 32'd0 : (m2_r ^ (m2_r >> 16));
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      meta1_r <= meta0;
      for (int i = 0; i < KEY_WORDS; i++) begin
        p1_r[i] <= word0[i] * MM_C1;
      end
    end
    if (en2 && v1_r) begin
      meta2_r <= meta1_r;
      for (int i = 0; i < KEY_WORDS; i++) begin
        k2_r[i] <= k2_nxt[i];
      end
    end
    if (en3 && v2_r) begin
      meta3_r <= meta2_r;
      h2_r    <= h2_nxt;
      k3_r    <= k2_r[2];
      k4_r    <= k2_r[3];
    end
    if (en4 && v3_r) begin
      meta4_r <= meta3_r;
      hp_r    <= hp_nxt;
    end
    if (en5 && v4_r) begin
      meta5_r <= meta4_r;
      m1_r    <= hp_r * MM_F1;
    end
    if (en6 && v5_r) begin
      meta6_r <= meta5_r;
      m2_r    <= m1x * MM_F2;
    end
  end

  logic      mod_vld [MOD_STAGES+1];
  logic      mod_rdy [MOD_STAGES+1];
  ehps_mod_t mod_dat [MOD_STAGES+1];

  assign mod_vld[0]     = v6_r;
  assign mod_ready      = mod_rdy[0];
  assign mod_dat[0].unsup = meta6_r.unsup;
  assign mod_dat[0].cnt   = meta6_r.cnt;
  assign mod_dat[0].rem   = 5'd0;
  assign mod_dat[0].hash  = hash6;

  for (genvar g = 0; g < MOD_STAGES; g++) begin : g_mod
    ehps_mod_stage #(
      .STG(g)
    ) u_mod (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_valid(mod_vld[g]),
      .up_ready(mod_rdy[g]),
      .up_data (mod_dat[g]),
      .dn_valid(mod_vld[g+1]),
      .dn_ready(mod_rdy[g+1]),
      .dn_data (mod_dat[g+1])
    );
  end

  assign mod_rdy[MOD_STAGES]  = out_ready;
  assign out_valid            = mod_vld[MOD_STAGES];
  assign out_data.path_index  = mod_dat[MOD_STAGES].rem[3:0];
  assign out_data.hash_value  = mod_dat[MOD_STAGES].hash;
  assign out_data.unsupported = mod_dat[MOD_STAGES].unsup;

  a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.unsupported |->
      (out_data.path_index == 4'd0) && (out_data.hash_value == 32'd0))
    else $error("unsupported item carries nonzero result");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted item missing from first stage");

  a_hash_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r && !mod_ready |=> v6_r && $stable(m2_r) && $stable(meta6_r))
    else $error("stalled hash stage changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !v1_r)
    else $error("pipeline not empty after reset");

endmodule

/* tb/tb_ecmp_hash_path_select.sv */
// Self-checking testbench for ecmp_hash_path_select: drives packet headers under several
// seed and spray settings and checks every path index, hash value and unsupported flag.
// Depends on ehps_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_ecmp_hash_path_select;
  import ehps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PATH_MAX    = 16;
  localparam int unsigned PHASE_ITEMS = 190;

  localparam logic [7:0] P_TCP       = PROTO_TCP;
  localparam logic [7:0] P_UDP       = PROTO_UDP;
  localparam logic [7:0] P_ACK       = PROTO_ACK;
  localparam logic [7:0] P_NACK      = PROTO_NACK;
  localparam logic [7:0] P_CTRL_LOW  = PROTO_CTRL_MIN;
  localparam logic [7:0] P_RSVD_FE   = 8'hFE;
  localparam logic [7:0] P_RSVD_FF   = 8'hFF;
  localparam logic [1:0] T_SPRAY     = TAG_SPRAY;
  localparam logic [1:0] T_NONE      = 2'd3;

  localparam logic [31:0] K_C1 = 32'hcc9e2d51;
  localparam logic [31:0] K_C2 = 32'h1b873593;
  localparam logic [31:0] K_N  = 32'he6546b64;
  localparam logic [31:0] K_F1 = 32'h85ebca6b;
  localparam logic [31:0] K_F2 = 32'hc2b2ae35;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  ehps_in_t                in_data = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  ehps_out_t               out_data;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  logic [31:0] seed_shadow = '0;
  logic        spray_shadow = 1'b0;

  ehps_in_t  header_q[$];
  ehps_out_t path_exp_q[$];
  ehps_out_t next_path;
  ehps_out_t pred_item;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned sent_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned unsup_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned setting_cnt = 1;
  int unsigned cycle_cnt = 0;

  logic [15:0] rx_pattern = 16'hFFFF;
  logic [3:0]  rx_pos = 4'd0;

  ecmp_hash_path_select dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] k;
    logic [31:0] acc;
    k = w * K_C1;
    k = {k[16:0], k[31:17]};
    k = k * K_C2;
    acc = h ^ k;
    acc = {acc[18:0], acc[31:19]};
    return acc * 32'd5 + K_N;
  endfunction

  function automatic ehps_out_t predict_path(input ehps_in_t p);
    logic [31:0] h;
    logic [31:0] modv;
    logic [4:0]  cnt;
    logic        ctrl;
    logic        spray;
    logic        known;
    ehps_out_t   r;
    r = '0;
    ctrl = p.protocol >= P_CTRL_LOW;
    spray = spray_shadow && (p.workload_tag == T_SPRAY) && !ctrl;
    known = (p.protocol == P_TCP) || (p.protocol == P_UDP) ||
            (p.protocol == P_ACK) || (p.protocol == P_NACK);
    cnt = p.path_count;
    if (cnt == 5'd0) begin
      cnt = 5'd1;
    end
    if (cnt > PATH_MAX) begin
      cnt = 5'(PATH_MAX);
    end
    if (!spray && !known) begin
      r.unsupported = 1'b1;
      return r;
    end
    h = seed_shadow;
    h = mix_word(h, p.src_ip);
    h = mix_word(h, p.dst_ip);
    h = mix_word(h, {p.dst_port, p.src_port});
    if (spray) begin
      h = mix_word(h, p.seq_num);
      h = h ^ 32'd16;
    end else begin
      h = h ^ 32'd12;
    end
    h = h ^ (h >> 16);
    h = h * K_F1;
    h = h ^ (h >> 13);
    h = h * K_F2;
    h = h ^ (h >> 16);
    modv = h % {27'd0, cnt};
    r.path_index = modv[3:0];
    r.hash_value = h;
    return r;
  endfunction

  function automatic ehps_in_t make_header(input logic [7:0] proto, input logic [1:0] tag,
                                           input logic [4:0] cnt);
    ehps_in_t p;
    p.src_ip = $urandom;
    p.dst_ip = $urandom;
    p.protocol = proto;
    p.src_port = 16'($urandom);
    p.dst_port = 16'($urandom);
    p.seq_num = $urandom;
    p.workload_tag = tag;
    p.path_count = cnt;
    return p;
  endfunction

  function automatic ehps_in_t random_header();
    logic [7:0] proto;
    logic [1:0] tag;
    logic [4:0] cnt;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      proto = P_TCP;
    end else if (pick < 55) begin
      proto = P_UDP;
    end else if (pick < 65) begin
      proto = ($urandom_range(0, 1) == 0) ? P_ACK : P_NACK;
    end else if (pick < 75) begin
      proto = 8'(P_CTRL_LOW + $urandom_range(2, 3));
    end else begin
      proto = 8'($urandom_range(0, 255));
    end
    tag = ($urandom_range(0, 9) < 4) ? T_SPRAY : 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) begin
      cnt = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
    end else begin
      cnt = 5'($urandom_range(1, 16));
    end
    return make_header(proto, tag, cnt);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at result %0d, %s: got %h, expected %h", checked_cnt, what, got, want);
    err_cnt++;
  endtask

  task automatic add_header(input ehps_in_t p);
    header_q.insert(header_q.size(), p);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    if (idx == REG_HASH_SEED) begin
      seed_shadow = val;
    end else begin
      spray_shadow = val[0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (header_q.size() != 0 || in_valid || path_exp_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic load_directed();
    ehps_in_t p;
    p = '0;
    p.protocol = P_TCP;
    p.path_count = 5'd1;
    add_header(p);
    p = '1;
    p.protocol = P_UDP;
    p.workload_tag = T_NONE;
    p.path_count = 5'd16;
    add_header(p);
    add_header(make_header(P_TCP, T_SPRAY, 5'd0));
    add_header(make_header(P_UDP, T_SPRAY, 5'd31));
    add_header(make_header(P_ACK, T_SPRAY, 5'd17));
    add_header(make_header(P_NACK, 2'd1, 5'd7));
    add_header(make_header(P_RSVD_FE, T_SPRAY, 5'd5));
    add_header(make_header(P_RSVD_FF, 2'd0, 5'd3));
    add_header(make_header(8'h00, T_SPRAY, 5'd16));
    add_header(make_header(8'h2F, T_NONE, 5'd9));
    add_header(make_header(8'h07, 2'd1, 5'd2));
    add_header(make_header(8'h05, T_SPRAY, 5'd15));
  endtask

  task automatic load_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      add_header(random_header());
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pred_item = predict_path(in_data);
        if (pred_item.unsupported) begin
          unsup_cnt++;
        end
        path_exp_q.insert(path_exp_q.size(), pred_item);
        sent_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (header_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= header_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (path_exp_q.size() == 0) begin
          report_mismatch("result with nothing expected", out_data.hash_value, '0);
        end else begin
          next_path = path_exp_q.pop_front();
          if (out_data.path_index !== next_path.path_index) begin
            report_mismatch("path_index", 32'(out_data.path_index), 32'(next_path.path_index));
          end
          if (out_data.hash_value !== next_path.hash_value) begin
            report_mismatch("hash_value", out_data.hash_value, next_path.hash_value);
          end
          if (out_data.unsupported !== next_path.unsupported) begin
            report_mismatch("unsupported", 32'(out_data.unsupported),
                            32'(next_path.unsupported));
          end
        end
        checked_cnt++;
      end
      out_ready <= rx_pattern[rx_pos];
      if (rx_pos == 4'd15) begin
        rx_pos = 4'd0;
        case ($urandom_range(0, 3))
          0: begin
            rx_pattern = 16'hFFFF;
          end
          1: begin
            rx_pattern = 16'($urandom);
          end
          2: begin
            rx_pattern = 16'($urandom) | 16'($urandom);
          end
          default: begin
            rx_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
          end
        endcase
      end else begin
        rx_pos++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_cnt,
               path_exp_q.size());
      $display("tb_ecmp_hash_path_select failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] seed_val;
    logic        spray_val;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    load_directed();
    wait_drained();

    write_reg(REG_HASH_SEED, 32'hFFFFFFFF);
    write_reg(REG_SPRAY_ENABLE, 32'hFFFFFFFF);
    setting_cnt++;
    load_directed();
    wait_drained();

    for (int unsigned ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          seed_val = $urandom;
          spray_val = 1'b1;
        end
        1: begin
          seed_val = 32'h0;
          spray_val = 1'b0;
        end
        2: begin
          seed_val = $urandom;
          spray_val = 1'b1;
        end
        3: begin
          seed_val = 32'hFFFFFFFF;
          spray_val = 1'b0;
        end
        default: begin
          seed_val = 32'h80000000;
          spray_val = 1'b1;
        end
      endcase
      write_reg(REG_HASH_SEED, seed_val);
      write_reg(REG_SPRAY_ENABLE, (32'($urandom) & 32'hFFFFFFFE) | 32'(spray_val));
      setting_cnt++;
      if (ph == 2) begin
        load_random(PHASE_ITEMS / 2);
        wait_drained();
        load_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        load_random(PHASE_ITEMS);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d headers and checked %0d results under %0d register settings.",
             sent_cnt, checked_cnt, setting_cnt);
    $display("%0d results carried the unsupported flag; %0d mismatches seen.",
             unsup_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_ecmp_hash_path_select passed");
    end else begin
      $display("tb_ecmp_hash_path_select failed");
    end
    $finish;
  end

endmodule
